[rtl/hwfw_pkg.sv]
// ----------------------------------------------------------------------------
// hwfw_pkg
// Types, constants and lookup functions for the half-width to full-width
// codepoint converter.
// ----------------------------------------------------------------------------
package hwfw_pkg;

   localparam int CP_W       = 21;
   localparam int BASE_W     = 16;
   localparam int QUEUE_AW   = 2;
   localparam int QUEUE_D    = 1 << QUEUE_AW;

   localparam logic [CP_W-1:0]   CP_SPACE      = 21'h000020;
   localparam logic [CP_W-1:0]   CP_ASCII_LO   = 21'h000021;
   localparam logic [CP_W-1:0]   CP_ASCII_HI   = 21'h00007E;
   localparam logic [CP_W-1:0]   CP_IDEO_SPACE = 21'h003000;
   localparam logic [CP_W-1:0]   FW_OFFSET     = 21'h00FEE0;
   localparam logic [CP_W-1:0]   CP_DAKUTEN    = 21'h00FF9E;
   localparam logic [CP_W-1:0]   CP_HANDAKUTEN = 21'h00FF9F;
   localparam logic [CP_W-1:0]   CP_KANA_LO    = 21'h00FF66;
   localparam logic [CP_W-1:0]   CP_KANA_HI    = 21'h00FF9D;
   localparam logic [CP_W-1:0]   CP_FW_DAKU    = 21'h00309B;
   localparam logic [CP_W-1:0]   CP_FW_HANDAKU = 21'h00309C;
   localparam logic [5:0]        KANA_IDX_BIAS = 6'h26;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            run_last;
      logic            text_last;
   } rsp_entry_type;

   // full-width base for half-width katakana, indexed from U+FF66
   function automatic logic [BASE_W-1:0] kana_base(input logic [5:0] idx);
      logic [BASE_W-1:0] b;
      case (idx)
         6'd0:  b = 16'h30F2;
         6'd1:  b = 16'h30A1;
         6'd2:  b = 16'h30A3;
         6'd3:  b = 16'h30A5;
         6'd4:  b = 16'h30A7;
         6'd5:  b = 16'h30A9;
         6'd6:  b = 16'h30E3;
         6'd7:  b = 16'h30E5;
         6'd8:  b = 16'h30E7;
         6'd9:  b = 16'h30C3;
         6'd10: b = 16'h30FC;
         6'd11: b = 16'h30A2;
         6'd12: b = 16'h30A4;
         6'd13: b = 16'h30A6;
         6'd14: b = 16'h30A8;
         6'd15: b = 16'h30AA;
         6'd16: b = 16'h30AB;
         6'd17: b = 16'h30AD;
         6'd18: b = 16'h30AF;
         6'd19: b = 16'h30B1;
         6'd20: b = 16'h30B3;
         6'd21: b = 16'h30B5;
         6'd22: b = 16'h30B7;
         6'd23: b = 16'h30B9;
         6'd24: b = 16'h30BB;
         6'd25: b = 16'h30BD;
         6'd26: b = 16'h30BF;
         6'd27: b = 16'h30C1;
         6'd28: b = 16'h30C4;
         6'd29: b = 16'h30C6;
         6'd30: b = 16'h30C8;
         6'd31: b = 16'h30CA;
         6'd32: b = 16'h30CB;
         6'd33: b = 16'h30CC;
         6'd34: b = 16'h30CD;
         6'd35: b = 16'h30CE;
         6'd36: b = 16'h30CF;
         6'd37: b = 16'h30D2;
         6'd38: b = 16'h30D5;
         6'd39: b = 16'h30D8;
         6'd40: b = 16'h30DB;
         6'd41: b = 16'h30DE;
         6'd42: b = 16'h30DF;
         6'd43: b = 16'h30E0;
         6'd44: b = 16'h30E1;
         6'd45: b = 16'h30E2;
         6'd46: b = 16'h30E4;
         6'd47: b = 16'h30E6;
         6'd48: b = 16'h30E8;
         6'd49: b = 16'h30E9;
         6'd50: b = 16'h30EA;
         6'd51: b = 16'h30EB;
         6'd52: b = 16'h30EC;
         6'd53: b = 16'h30ED;
         6'd54: b = 16'h30EF;
         6'd55: b = 16'h30F3;
         default: b = 16'h0000;
      endcase
      return b;
   endfunction

   // h-row bases take both marks
   function automatic logic is_h_row(input logic [BASE_W-1:0] b);
      return (b == 16'h30CF) || (b == 16'h30D2) || (b == 16'h30D5) ||
             (b == 16'h30D8) || (b == 16'h30DB);
   endfunction

   // voiced form, zero when there is none
   function automatic logic [BASE_W-1:0] voiced_of(input logic [BASE_W-1:0] b);
      logic [BASE_W-1:0] r;
      r = '0;
      if (b == 16'h30A6) begin
         r = 16'h30F4;
      end else if ((b == 16'h30C1) || (b == 16'h30C4) || (b == 16'h30C6) ||
                   (b == 16'h30C8) || is_h_row(b)) begin
         r = b + 16'd1;
      end else if ((b >= 16'h30AB) && (b <= 16'h30BF) && b[0]) begin
         // k and s rows plus ta: every other codepoint from U+30AB
         r = b + 16'd1;
      end
      return r;
   endfunction

   function automatic logic [BASE_W-1:0] semi_voiced_of(input logic [BASE_W-1:0] b);
      return is_h_row(b) ? b + 16'd2 : '0;
   endfunction

   function automatic logic [CP_W-1:0] map_plain(input logic [CP_W-1:0] c);
      logic [CP_W-1:0] r;
      r = c;
      if (c == CP_SPACE) begin
         r = CP_IDEO_SPACE;
      end else if ((c >= CP_ASCII_LO) && (c <= CP_ASCII_HI)) begin
         r = c + FW_OFFSET;
      end else begin
         case (c)
            21'h00FF61: r = 21'h003002;
            21'h00FF62: r = 21'h00300C;
            21'h00FF63: r = 21'h00300D;
            21'h00FF64: r = 21'h003001;
            21'h00FF65: r = 21'h0030FB;
            CP_DAKUTEN:    r = CP_FW_DAKU;
            CP_HANDAKUTEN: r = CP_FW_HANDAKU;
            default:    r = c;
         endcase
      end
      return r;
   endfunction

endpackage

[rtl/halfwidth_to_fullwidth_converter_top.sv]
// ----------------------------------------------------------------------------
// halfwidth_to_fullwidth_converter_top
// Converts a stream of codepoints to full-width forms, merging half-width
// katakana with a following sound mark.
// ----------------------------------------------------------------------------
// Input channel req_*: one codepoint per transaction, with end_of_text on the
// last codepoint of a text. Output channel rsp_*: zero, one or two converted
// codepoints per input transaction; run_last flags the last one caused by an
// input, text_last the final one of a text.
// A half-width katakana is held in a one-entry pending register until the
// next codepoint shows whether a sound mark merges with it, so its output
// comes with that next codepoint's results unless it ends the text.
// Results enter a four-entry output queue in the cycle of acceptance and
// reach rsp_* from the queue registers. Input is taken whenever the queue holds
// two or fewer entries, so one codepoint per cycle is sustained while the
// receiver keeps up; an input giving two results fills two queue entries.
// A stalled receiver fills the queue and then req_ready drops.
// Reset empties the queue and drops any held katakana.
// ----------------------------------------------------------------------------
module halfwidth_to_fullwidth_converter_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [hwfw_pkg::CP_W-1:0]     req_code_point,
   input  logic                          req_end_of_text,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hwfw_pkg::CP_W-1:0]     rsp_out_code_point,
   output logic                          rsp_run_last,
   output logic                          rsp_text_last
);

   localparam int CNT_W = hwfw_pkg::QUEUE_AW + 1;

   logic                               pending_ff, pending_in;
   logic [hwfw_pkg::BASE_W-1:0]        base_ff, base_in;

   hwfw_pkg::rsp_entry_type            queue_ff [hwfw_pkg::QUEUE_D];
   logic [hwfw_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [hwfw_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                   count_ff, count_in;

   logic                               push, pop;
   logic                               is_kana, consumed;
   logic [hwfw_pkg::BASE_W-1:0]        kana_b, merged;
   hwfw_pkg::rsp_entry_type            res0, res1;
   logic [1:0]                         num_res;
   logic [hwfw_pkg::QUEUE_AW-1:0]      wr_ptr_next1;
   hwfw_pkg::rsp_entry_type            head;

   assign req_ready = (count_ff <= CNT_W'(hwfw_pkg::QUEUE_D - 2));
   assign push      = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;

   assign head               = queue_ff[rd_ptr_ff];
   assign rsp_out_code_point = head.code_point;
   assign rsp_run_last       = head.run_last;
   assign rsp_text_last      = head.text_last;

   assign wr_ptr_next1 = wr_ptr_ff + hwfw_pkg::QUEUE_AW'(1);

   // conversion of one input transaction into up to two results
   always_comb begin
      logic                       emit_new;
      logic [hwfw_pkg::CP_W-1:0]  new_cp;
      hwfw_pkg::rsp_entry_type    e_new;

      is_kana = (req_code_point >= hwfw_pkg::CP_KANA_LO) &&
                (req_code_point <= hwfw_pkg::CP_KANA_HI);
      kana_b  = hwfw_pkg::kana_base(req_code_point[5:0] - hwfw_pkg::KANA_IDX_BIAS);

      merged = '0;
      if (req_code_point == hwfw_pkg::CP_DAKUTEN) begin
         merged = hwfw_pkg::voiced_of(base_ff);
      end else if (req_code_point == hwfw_pkg::CP_HANDAKUTEN) begin
         merged = hwfw_pkg::semi_voiced_of(base_ff);
      end
      consumed = pending_ff && (merged != '0);

      emit_new = !consumed && (!is_kana || req_end_of_text);
      new_cp   = is_kana ? hwfw_pkg::CP_W'(kana_b) : hwfw_pkg::map_plain(req_code_point);

      e_new.code_point = new_cp;
      e_new.run_last   = 1'b1;
      e_new.text_last  = req_end_of_text;

      res0 = e_new;
      res1 = e_new;
      num_res = {1'b0, emit_new};
      if (pending_ff) begin
         res0.code_point = hwfw_pkg::CP_W'(consumed ? merged : base_ff);
         res0.run_last   = !emit_new;
         res0.text_last  = req_end_of_text && !emit_new;
         num_res         = emit_new ? 2'd2 : 2'd1;
      end

      pending_in = pending_ff;
      base_in    = base_ff;
      if (push) begin
         pending_in = !consumed && is_kana && !req_end_of_text;
         base_in    = pending_in ? kana_b : '0;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + hwfw_pkg::QUEUE_AW'(push ? num_res : 2'd0);
      rd_ptr_in = rd_ptr_ff + hwfw_pkg::QUEUE_AW'(pop);
      count_in  = count_ff + CNT_W'(push ? num_res : 2'd0) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         base_ff    <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         base_ff    <= base_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
      end
   end

   // queue payload, no reset needed
   always_ff @(posedge clock) begin
      if (push && (num_res != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push && (num_res == 2'd2)) begin
         queue_ff[wr_ptr_next1] <= res1;
      end
   end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the half-width to full-width converter: a short
// directed text walks the mapping corners, then random texts heavy in
// katakana and sound marks run with random gaps and stalls on both sides;
// every result is compared field by field against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;

   localparam int CPW = hwfw_pkg::CP_W;

   // half-width punctuation and its full-width forms
   localparam logic [CPW-1:0] HW_STOP   = 21'h00FF61;
   localparam logic [CPW-1:0] HW_OPEN   = 21'h00FF62;
   localparam logic [CPW-1:0] HW_CLOSE  = 21'h00FF63;
   localparam logic [CPW-1:0] HW_COMMA  = 21'h00FF64;
   localparam logic [CPW-1:0] HW_MIDDOT = 21'h00FF65;
   localparam logic [CPW-1:0] FW_STOP   = 21'h003002;
   localparam logic [CPW-1:0] FW_OPEN   = 21'h00300C;
   localparam logic [CPW-1:0] FW_CLOSE  = 21'h00300D;
   localparam logic [CPW-1:0] FW_COMMA  = 21'h003001;
   localparam logic [CPW-1:0] FW_MIDDOT = 21'h0030FB;

   // full-width base of each half-width katakana, first entry in the top bits
   localparam logic [56*16-1:0] KANA_FULL_ROM = {
      16'h30F2, 16'h30A1, 16'h30A3, 16'h30A5, 16'h30A7, 16'h30A9,
      16'h30E3, 16'h30E5, 16'h30E7, 16'h30C3, 16'h30FC,
      16'h30A2, 16'h30A4, 16'h30A6, 16'h30A8, 16'h30AA,
      16'h30AB, 16'h30AD, 16'h30AF, 16'h30B1, 16'h30B3,
      16'h30B5, 16'h30B7, 16'h30B9, 16'h30BB, 16'h30BD,
      16'h30BF, 16'h30C1, 16'h30C4, 16'h30C6, 16'h30C8,
      16'h30CA, 16'h30CB, 16'h30CC, 16'h30CD, 16'h30CE,
      16'h30CF, 16'h30D2, 16'h30D5, 16'h30D8, 16'h30DB,
      16'h30DE, 16'h30DF, 16'h30E0, 16'h30E1, 16'h30E2,
      16'h30E4, 16'h30E6, 16'h30E8,
      16'h30E9, 16'h30EA, 16'h30EB, 16'h30EC, 16'h30ED,
      16'h30EF, 16'h30F3
   };

   class fullwidth_scoreboard;
      hwfw_pkg::rsp_entry_type expected_q[$];
      bit          kana_held;
      logic [15:0] held_base;
      int          errors;
      int          results_seen;
      int          merges;
      int          texts;

      function logic [15:0] kana_full(logic [CPW-1:0] cp);
         int idx;
         idx = int'(cp - hwfw_pkg::CP_KANA_LO);
         return KANA_FULL_ROM[(55 - idx)*16 +: 16];
      endfunction

      function bit h_row(logic [15:0] b);
         return (b == 16'h30CF) || (b == 16'h30D2) || (b == 16'h30D5) ||
                (b == 16'h30D8) || (b == 16'h30DB);
      endfunction

      // zero when the base has no voiced form
      function logic [15:0] voiced_form(logic [15:0] b);
         if (b == 16'h30A6) return 16'h30F4;
         if ((b == 16'h30C1) || (b == 16'h30C4) || (b == 16'h30C6) || (b == 16'h30C8))
            return b + 16'd1;
         // k and s rows plus ta sit on every other codepoint from U+30AB
         if ((b >= 16'h30AB) && (b <= 16'h30BF) && (((b - 16'h30AB) & 16'd1) == 0))
            return b + 16'd1;
         if (h_row(b)) return b + 16'd1;
         return 16'h0000;
      endfunction

      function logic [15:0] semi_voiced_form(logic [15:0] b);
         return h_row(b) ? b + 16'd2 : 16'h0000;
      endfunction

      function logic [CPW-1:0] fullwidth_of(logic [CPW-1:0] c);
         if (c == hwfw_pkg::CP_SPACE) return hwfw_pkg::CP_IDEO_SPACE;
         if ((c >= hwfw_pkg::CP_ASCII_LO) && (c <= hwfw_pkg::CP_ASCII_HI))
            return c + hwfw_pkg::FW_OFFSET;
         case (c)
            HW_STOP:                 return FW_STOP;
            HW_OPEN:                 return FW_OPEN;
            HW_CLOSE:                return FW_CLOSE;
            HW_COMMA:                return FW_COMMA;
            HW_MIDDOT:               return FW_MIDDOT;
            hwfw_pkg::CP_DAKUTEN:    return hwfw_pkg::CP_FW_DAKU;
            hwfw_pkg::CP_HANDAKUTEN: return hwfw_pkg::CP_FW_HANDAKU;
            default:                 return c;
         endcase
      endfunction

      function void note_codepoint(logic [CPW-1:0] cp, bit eot);
         logic [CPW-1:0]          outs [2];
         int                      n;
         bit                      consumed;
         logic [15:0]             merged;
         hwfw_pkg::rsp_entry_type e;
         n = 0;
         consumed = 0;
         merged = '0;
         if (kana_held) begin
            if (cp == hwfw_pkg::CP_DAKUTEN) merged = voiced_form(held_base);
            else if (cp == hwfw_pkg::CP_HANDAKUTEN) merged = semi_voiced_form(held_base);
            if (merged != 0) begin
               outs[n] = CPW'(merged);
               consumed = 1;
               merges++;
            end else begin
               outs[n] = CPW'(held_base);
            end
            n++;
            kana_held = 0;
            held_base = '0;
         end
         if (!consumed) begin
            if ((cp >= hwfw_pkg::CP_KANA_LO) && (cp <= hwfw_pkg::CP_KANA_HI)) begin
               if (eot) begin
                  outs[n] = CPW'(kana_full(cp));
                  n++;
               end else begin
                  kana_held = 1;
                  held_base = kana_full(cp);
               end
            end else begin
               outs[n] = fullwidth_of(cp);
               n++;
            end
         end
         for (int i = 0; i < n; i++) begin
            e.code_point = outs[i];
            e.run_last   = (i == n - 1);
            e.text_last  = eot && (i == n - 1);
            expected_q.insert(expected_q.size(), e);
         end
         if (eot) begin
            kana_held = 0;
            held_base = '0;
            texts++;
         end
      endfunction

      function void check_result(logic [CPW-1:0] cp, logic rl, logic tl);
         hwfw_pkg::rsp_entry_type e;
         results_seen++;
         if (expected_q.size() == 0) begin
            $error("unexpected result: out_code_point %h run_last %b text_last %b",
                   cp, rl, tl);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (cp !== e.code_point) begin
            $error("out_code_point: expected %h, got %h", e.code_point, cp);
            errors++;
         end
         if (rl !== e.run_last) begin
            $error("run_last: expected %b, got %b", e.run_last, rl);
            errors++;
         end
         if (tl !== e.text_last) begin
            $error("text_last: expected %b, got %b", e.text_last, tl);
            errors++;
         end
      endfunction
   endclass

   logic           clock = 1'b0;
   logic           reset;
   logic           req_valid;
   logic           req_ready;
   logic [CPW-1:0] req_code_point;
   logic           req_end_of_text;
   logic           rsp_valid;
   logic           rsp_ready;
   logic [CPW-1:0] rsp_out_code_point;
   logic           rsp_run_last;
   logic           rsp_text_last;

   fullwidth_scoreboard ledger = new();
   int                  codepoints_sent;

   halfwidth_to_fullwidth_converter_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_code_point     (req_code_point),
      .req_end_of_text    (req_end_of_text),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_code_point (rsp_out_code_point),
      .rsp_run_last       (rsp_run_last),
      .rsp_text_last      (rsp_text_last)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_result(rsp_out_code_point, rsp_run_last, rsp_text_last);
   end

   // receiver: random stalls, one long hold-off and a stretch that never stalls
   initial begin
      int taken;
      bit held_once;
      taken = 0;
      held_once = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) taken++;
         if (taken >= 250 && !held_once) begin
            held_once = 1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         rsp_ready <= !reset && (((taken >= 500) && (taken < 700)) ||
                                 ($urandom_range(0, 99) >= 33));
      end
   end

   task automatic send_codepoint(input logic [CPW-1:0] cp, input bit eot);
      req_valid       <= 1'b1;
      req_code_point  <= cp;
      req_end_of_text <= eot;
      do @(posedge clock); while (!req_ready);
      ledger.note_codepoint(cp, eot);
      codepoints_sent++;
      // no gaps between transactions in the middle stretch
      if (!((codepoints_sent >= 400) && (codepoints_sent < 600)) &&
          ($urandom_range(0, 99) < 33)) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   function automatic logic [CPW-1:0] pick_codepoint(bit after_kana);
      int r;
      r = $urandom_range(0, 99);
      if (after_kana && r < 50)
         return $urandom_range(0, 1) ? hwfw_pkg::CP_DAKUTEN : hwfw_pkg::CP_HANDAKUTEN;
      r = $urandom_range(0, 99);
      if (r < 35) return CPW'($urandom_range(hwfw_pkg::CP_KANA_LO, hwfw_pkg::CP_KANA_HI));
      if (r < 48)
         return $urandom_range(0, 1) ? hwfw_pkg::CP_DAKUTEN : hwfw_pkg::CP_HANDAKUTEN;
      if (r < 63) return CPW'($urandom_range(0, 127));
      if (r < 70) return CPW'($urandom_range(HW_STOP, HW_MIDDOT));
      if (r < 77) return CPW'($urandom_range(21'h00FF5E, 21'h00FFA2));
      if (r < 88) return CPW'($urandom_range(0, 16'hFFFF));
      return CPW'($urandom() & 21'h1FFFFF);
   endfunction

   initial begin
      logic [CPW-1:0] directed_cp  [25];
      bit             directed_eot [25];
      int             text_len;
      bit             after_kana;
      logic [CPW-1:0] cp;
      directed_cp = '{21'h000000, 21'h000020, 21'h000021, 21'h00007E, 21'h00007F,
                      21'h00001F, HW_STOP, HW_MIDDOT,
                      hwfw_pkg::CP_DAKUTEN, hwfw_pkg::CP_HANDAKUTEN,
                      21'h1FFFFF, 21'h00D800, 21'h10FFFF,
                      // ka + voiced mark, ha + semi-voiced mark, a + mark that fails
                      21'h00FF76, hwfw_pkg::CP_DAKUTEN,
                      21'h00FF8A, hwfw_pkg::CP_HANDAKUTEN,
                      21'h00FF71, hwfw_pkg::CP_DAKUTEN,
                      // table ends back to back, flushed by a letter at end of text
                      hwfw_pkg::CP_KANA_LO, hwfw_pkg::CP_KANA_HI, 21'h000041,
                      // lone katakana at end of text, then held base plus katakana
                      21'h00FF73, 21'h00FF73, 21'h00FF76};
      directed_eot = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                       0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 1};
      codepoints_sent = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_code_point  <= '0;
      req_end_of_text <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cp[i]) send_codepoint(directed_cp[i], directed_eot[i]);

      // random texts, katakana-heavy so that marks meet held bases often
      while (codepoints_sent < 1025) begin
         text_len = $urandom_range(1, 12);
         after_kana = 0;
         for (int k = 0; k < text_len; k++) begin
            cp = pick_codepoint(after_kana);
            after_kana = (cp >= hwfw_pkg::CP_KANA_LO) && (cp <= hwfw_pkg::CP_KANA_HI);
            send_codepoint(cp, k == text_len - 1);
         end
      end
      req_valid <= 1'b0;

      while (ledger.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d codepoints in %0d texts sent, %0d results checked, %0d marks merged",
               codepoints_sent, ledger.texts, ledger.results_seen, ledger.merges);
      if (ledger.errors == 0 && ledger.expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

endmodule
